// ===== hdl/s256_pkg.sv =====
// s256_pkg: shared constants, round table and helper functions for the
// SHA-256 stream hasher. No dependencies.
package s256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned PadOffset  = 56;
  localparam int unsigned Rounds     = 64;
  localparam logic [7:0]  PadByte    = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t iv_word(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h6A09E667;
      3'd1: r = 32'hBB67AE85;
      3'd2: r = 32'h3C6EF372;
      3'd3: r = 32'hA54FF53A;
      3'd4: r = 32'h510E527F;
      3'd5: r = 32'h9B05688C;
      3'd6: r = 32'h1F83D9AB;
      default: r = 32'h5BE0CD19;
    endcase
    return r;
  endfunction

  localparam word_t RoundK [64] = '{
    32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
    32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
    32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
    32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
    32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
    32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
    32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
    32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
    32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
    32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
    32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
    32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
    32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
    32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
    32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
    32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== hdl/s256_round.sv =====
// s256_round: one SHA-256 compression round per cycle while step is high, shared
// over all 64 rounds, with the rolling 16-word message schedule. Depends on s256_pkg.
module s256_round import s256_pkg::*; (
  input  logic        clk,
  input  logic        load,      // start a block: copy chain into working vars
  input  logic        step,      // run one round
  input  logic [5:0]  rnd,
  input  word_t       chain [8],
  input  word_t       blk_word,  // schedule word for rounds 0..15
  output word_t       vars [8]
);

  word_t v_r [8];
  word_t w_r [16];
  word_t w, s0, s1, t1, t2, x15, x2;

  // build schedule word and round sums
  always_comb begin
    x15 = w_r[rnd[3:0] - 4'd15];
    x2  = w_r[rnd[3:0] - 4'd2];
    s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    w   = (rnd < 6'd16) ? blk_word
          : w_r[rnd[3:0]] + s0 + w_r[rnd[3:0] - 4'd7] + s1;
    t1  = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
          + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + RoundK[rnd] + w;
    t2  = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
          + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  // advance working vars and schedule window
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 8; i++) v_r[i] <= chain[i];
    end else if (step) begin
      w_r[rnd[3:0]] <= w;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
  end

  assign vars = v_r;

endmodule

// ===== hdl/sha256_stream_hasher.sv =====
// sha256_stream_hasher: top level, byte intake, padding sequencer and
// digest output. Depends on s256_pkg and s256_round.
//
// Takes at most one message byte per request (none when in_has_data is low);
// every 64th byte (and each padding block) runs all 64 rounds of the shared
// round unit and then a fold into the chain, during which in_ready is low.
// The final request then pads (byte by byte for the marker, the zero fill
// and the length), compresses once or twice, and delivers eight digest
// words, one per accepted out request, before taking the next message.
module sha256_stream_hasher import s256_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_data,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  localparam logic [2:0] StIdle = 3'd0, StRound = 3'd1, StFold = 3'd2,
                         StPad = 3'd3, StOut = 3'd4;

  logic [2:0]  st_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [5:0]  rnd_r;
  logic        fin_r;     // padding in progress
  logic        lenblk_r;  // current block is the length block
  logic        mark_r;    // marker byte already placed
  logic [2:0]  oidx_r;
  word_t       buf_r [16];
  word_t       h_r [8];
  word_t       vars [8];
  word_t       blk_word;
  logic        load, step;
  logic        acc;
  logic        blk_full;
  logic [5:0]  nfill;
  logic [7:0]  pad_byte;

  assign acc      = in_valid && in_ready;
  assign in_ready = (st_r == StIdle);
  assign blk_full = in_has_data && (fill_r == 6'd63);
  assign nfill    = in_has_data ? fill_r + 6'd1 : fill_r;
  assign blk_word = buf_r[rnd_r[3:0]];
  assign load = (st_r == StIdle && acc && blk_full)
             || (st_r == StPad && fill_r == 6'd63);
  assign step = (st_r == StRound);

  // pick the padding byte: marker, zero, or big-endian length
  assign pad_byte = !mark_r ? PadByte
                  : (lenblk_r && fill_r >= 6'(PadOffset)) ? bits_r[{~fill_r[2:0], 3'b111} -: 8]
                  : 8'h00;

  s256_round u_round (
    .clk(clk), .load(load), .step(step), .rnd(rnd_r),
    .chain(h_r), .blk_word(blk_word), .vars(vars)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle; fill_r <= '0; bits_r <= '0; rnd_r <= '0;
      fin_r <= 1'b0; lenblk_r <= 1'b0; mark_r <= 1'b0; oidx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= iv_word(3'(i));
    end else begin
      case (st_r)
        StIdle: if (acc) begin
          if (in_has_data) begin
            buf_r[fill_r[5:2]][{~fill_r[1:0], 3'b111} -: 8] <= in_data_byte;
            bits_r <= bits_r + 64'd8;
          end
          fill_r <= nfill;
          fin_r <= in_last_byte;
          mark_r <= 1'b0;
          lenblk_r <= !blk_full && (nfill < 6'(PadOffset));
          rnd_r <= '0;
          if (blk_full) st_r <= StRound;
          else if (in_last_byte) st_r <= StPad;
        end
        StRound: begin
          rnd_r <= rnd_r + 6'd1;
          if (rnd_r == 6'(Rounds - 1)) st_r <= StFold;
        end
        StFold: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + vars[i];
          rnd_r <= '0;
          if (!fin_r) st_r <= StIdle;
          else if (lenblk_r) begin st_r <= StOut; oidx_r <= '0; end
          else begin
            // length did not fit: build the length block next
            fill_r <= 6'd0;
            lenblk_r <= 1'b1;
            st_r <= StPad;
          end
        end
        StPad: begin
          // marker first, then zero fill, then length bytes at the tail
          buf_r[fill_r[5:2]][{~fill_r[1:0], 3'b111} -: 8] <= pad_byte;
          mark_r <= 1'b1;
          fill_r <= fill_r + 6'd1;
          if (fill_r == 6'd63) begin st_r <= StRound; rnd_r <= '0; end
        end
        StOut: if (out_ready) begin
          oidx_r <= oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            st_r <= StIdle; fill_r <= '0; bits_r <= '0; fin_r <= 1'b0;
            for (int i = 0; i < 8; i++) h_r[i] <= iv_word(3'(i));
          end
        end
        default: st_r <= StIdle;
      endcase
    end
  end

  assign out_valid       = (st_r == StOut);
  assign out_digest_word = h_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  // check sequencer invariants
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid) else $error("ready while emitting");
  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == StRound && rnd_r == 6'd63) |=> st_r == StFold)
    else $error("round count slip");
  a_out_adv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word)
    |=> out_word_index == $past(out_word_index) + 3'd1)
    else $error("word index slip");

endmodule
